// File: src/assert_macros.svh
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// cause in one cycle, effect in the next
`define ASSERT_NEXT(lbl, clk, rst_n, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("assertion failed");

`endif

// File: src/wsg_pkg.sv
// types and constants of the weighted stress gradient unit
// used by the controller, the datapath and the top level
package wsg_pkg;

  localparam int COORD_W = 32;
  localparam int MAG_W   = 33;
  localparam int SUM_W   = 72;
  localparam int DIST_W  = 36;
  localparam int E_W     = 37;
  localparam int WT_W    = 17;
  localparam int TGT_W   = 31;
  localparam int OUT_W   = 48;
  localparam int MUL_W   = 89;
  localparam int MPL_W   = 36;
  localparam int A_W     = 54;
  localparam int NUM_W   = 87;
  localparam int REM_W   = 52;
  localparam int Q_W     = 64;
  localparam int CNT_W   = 7;
  localparam int GS_W    = 66;
  localparam int NCOORD  = 4;
  localparam int IN_DW   = 176;
  localparam int OUT_DW  = 248;
  localparam int CFG_DW  = 31;

  localparam logic CFG_DIMS   = 1'b0;
  localparam logic CFG_THRESH = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHECK, ST_SQ, ST_SQ_WAIT, ST_SQRT, ST_SQRT_WAIT,
    ST_E2, ST_E2_WAIT, ST_WE2, ST_WE2_WAIT, ST_STRESS, ST_LANE,
    ST_GMUL, ST_GMUL_WAIT, ST_GDIV, ST_GDIV_WAIT, ST_GACC, ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE, OP_SQ, OP_SQRT, OP_E2, OP_WE2, OP_GMUL, OP_GDIV
  } op_t;

  typedef struct packed {
    op_t  start;
    logic acc_sq;
    logic latch_e;
    logic acc_stress;
    logic acc_grad;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic busy;
    logic is_query;
    logic skip;
    logic last;
    logic dist_zero;
    logic lane_zero;
    logic out_busy;
  } dp_sts_t;

endpackage

// File: src/weighted_stress_gradient_unit.sv
// Weighted stress gradient unit: top level joining wsg_ctrl and wsg_dp
// depends on wsg_pkg
//
// Use: a query word (in_tuser = 0) loads the query point and clears the
// totals; each term word (in_tuser = 1) with target >= skip_threshold adds
// one reference term; a term word with in_tlast set emits one result word
// with stress, gradient, fault flags, then clears totals (query point kept).
// Configuration: cfg_index 0 = dims_in_use, 1 = skip_threshold, always ready.
// Timing: one word at a time; the bit-serial multiplier, root and divider
// set how long a computed term takes, and only lanes that take a gradient
// step use the gradient multiply and divide (no lanes when the distance is
// zero). Result appears in the cycle after the term finishes and sits in an
// output register; the next word is taken while it waits. A last term that
// finishes while the output register still holds an untaken result waits.
// Reset: synchronous, active low; clears totals, query point, fault bits,
// restores dims_in_use = 2 and skip_threshold = 1.
module weighted_stress_gradient_unit #(
  parameter int MAX_DIMS = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // coord_0, coord_1, coord_2, coord_3, term_weight, target_dist
  input  logic [wsg_pkg::IN_DW-1:0]   in_tdata,
  // cmd
  input  logic                        in_tuser,
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // stress, grad_0, grad_1, grad_2, grad_3, fault_flags, zero fill
  output logic [wsg_pkg::OUT_DW-1:0]  out_tdata,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic                        cfg_index,
  input  logic [wsg_pkg::CFG_DW-1:0]  cfg_data
);

  localparam int LANES = (MAX_DIMS < wsg_pkg::NCOORD) ? MAX_DIMS : wsg_pkg::NCOORD;
  localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;

  wsg_pkg::dp_cmd_t cmd;
  wsg_pkg::dp_sts_t sts;
  logic [IW-1:0]    lane;
  logic             in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  wsg_ctrl #(.LANES(LANES), .IW(IW)) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .sts      (sts),
    .in_ready (in_tready),
    .cmd      (cmd),
    .lane     (lane)
  );

  wsg_dp #(.MAX_DIMS(MAX_DIMS), .LANES(LANES), .IW(IW)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_cmd    (in_tuser),
    .in_last   (in_tlast),
    .in_data   (in_tdata),
    .cfg_fire  (cfg_valid && cfg_ready),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .cmd       (cmd),
    .lane      (lane),
    .out_ready (out_tready),
    .sts       (sts),
    .out_valid (out_tvalid),
    .out_data  (out_tdata)
  );

endmodule

// File: src/wsg_ctrl.sv
// sequencer of the weighted stress gradient unit
// depends on wsg_pkg; drives the datapath through dp_cmd_t
module wsg_ctrl #(
  parameter int LANES = 4,
  parameter int IW    = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  wsg_pkg::dp_sts_t  sts,
  output logic              in_ready,
  output wsg_pkg::dp_cmd_t  cmd,
  output logic [IW-1:0]     lane
);

  wsg_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]   lane_r, lane_nxt;
  logic            lane_end;

  assign lane     = lane_r;
  assign lane_end = (lane_r == IW'(LANES - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wsg_pkg::ST_IDLE;
      lane_r  <= '0;
    end else begin
      state_r <= state_nxt;
      lane_r  <= lane_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    lane_nxt  = lane_r;
    cmd       = '0;
    cmd.start = wsg_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      wsg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) state_nxt = wsg_pkg::ST_CHECK;
      end
      wsg_pkg::ST_CHECK: begin
        lane_nxt = '0;
        if (sts.is_query) state_nxt = wsg_pkg::ST_IDLE;
        else if (sts.skip) state_nxt = wsg_pkg::ST_FINISH;
        else state_nxt = wsg_pkg::ST_SQ;
      end
      wsg_pkg::ST_SQ: begin
        cmd.start = wsg_pkg::OP_SQ;
        state_nxt = wsg_pkg::ST_SQ_WAIT;
      end
      wsg_pkg::ST_SQ_WAIT: begin
        if (!sts.busy) begin
          cmd.acc_sq = 1'b1;
          if (lane_end) begin
            lane_nxt  = '0;
            state_nxt = wsg_pkg::ST_SQRT;
          end else begin
            lane_nxt  = lane_r + 1'b1;
            state_nxt = wsg_pkg::ST_SQ;
          end
        end
      end
      wsg_pkg::ST_SQRT: begin
        cmd.start = wsg_pkg::OP_SQRT;
        state_nxt = wsg_pkg::ST_SQRT_WAIT;
      end
      wsg_pkg::ST_SQRT_WAIT: begin
        if (!sts.busy) begin
          cmd.latch_e = 1'b1;
          state_nxt   = wsg_pkg::ST_E2;
        end
      end
      wsg_pkg::ST_E2: begin
        cmd.start = wsg_pkg::OP_E2;
        state_nxt = wsg_pkg::ST_E2_WAIT;
      end
      wsg_pkg::ST_E2_WAIT: begin
        if (!sts.busy) state_nxt = wsg_pkg::ST_WE2;
      end
      wsg_pkg::ST_WE2: begin
        cmd.start = wsg_pkg::OP_WE2;
        state_nxt = wsg_pkg::ST_WE2_WAIT;
      end
      wsg_pkg::ST_WE2_WAIT: begin
        if (!sts.busy) state_nxt = wsg_pkg::ST_STRESS;
      end
      wsg_pkg::ST_STRESS: begin
        cmd.acc_stress = 1'b1;
        lane_nxt       = '0;
        state_nxt      = sts.dist_zero ? wsg_pkg::ST_FINISH : wsg_pkg::ST_LANE;
      end
      wsg_pkg::ST_LANE: begin
        if (!sts.lane_zero) state_nxt = wsg_pkg::ST_GMUL;
        else if (lane_end) state_nxt = wsg_pkg::ST_FINISH;
        else lane_nxt = lane_r + 1'b1;
      end
      wsg_pkg::ST_GMUL: begin
        cmd.start = wsg_pkg::OP_GMUL;
        state_nxt = wsg_pkg::ST_GMUL_WAIT;
      end
      wsg_pkg::ST_GMUL_WAIT: begin
        if (!sts.busy) state_nxt = wsg_pkg::ST_GDIV;
      end
      wsg_pkg::ST_GDIV: begin
        cmd.start = wsg_pkg::OP_GDIV;
        state_nxt = wsg_pkg::ST_GDIV_WAIT;
      end
      wsg_pkg::ST_GDIV_WAIT: begin
        if (!sts.busy) state_nxt = wsg_pkg::ST_GACC;
      end
      wsg_pkg::ST_GACC: begin
        cmd.acc_grad = 1'b1;
        if (lane_end) begin
          state_nxt = wsg_pkg::ST_FINISH;
        end else begin
          lane_nxt  = lane_r + 1'b1;
          state_nxt = wsg_pkg::ST_LANE;
        end
      end
      wsg_pkg::ST_FINISH: begin
        // a last term waits for the output register to free up
        if (!sts.last) begin
          state_nxt = wsg_pkg::ST_IDLE;
        end else if (!sts.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = wsg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wsg_pkg::ST_IDLE;
    endcase
  end

endmodule

// File: src/wsg_dp.sv
// datapath of the weighted stress gradient unit: lanes, accumulators and
// one shared shift-add multiplier, square root and divider; uses wsg_pkg
module wsg_dp #(
  parameter int MAX_DIMS = 4,
  parameter int LANES    = 4,
  parameter int IW       = 2
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_fire,
  input  logic                          in_cmd,
  input  logic                          in_last,
  input  logic [wsg_pkg::IN_DW-1:0]     in_data,
  input  logic                          cfg_fire,
  input  logic                          cfg_idx,
  input  logic [wsg_pkg::CFG_DW-1:0]    cfg_wdata,
  input  wsg_pkg::dp_cmd_t              cmd,
  input  logic [IW-1:0]                 lane,
  input  logic                          out_ready,
  output wsg_pkg::dp_sts_t              sts,
  output logic                          out_valid,
  output logic [wsg_pkg::OUT_DW-1:0]    out_data
);

  localparam logic [wsg_pkg::OUT_W-1:0] MASK48 = '1;
  localparam logic signed [wsg_pkg::GS_W-1:0] SMAX =
    wsg_pkg::GS_W'(64'sh7FFF_FFFF_FFFF);
  localparam logic signed [wsg_pkg::GS_W-1:0] SMIN =
    -wsg_pkg::GS_W'(64'sh8000_0000_0000);

  logic [2:0]                     dims_r;
  logic [wsg_pkg::TGT_W-1:0]      thr_r;
  logic [wsg_pkg::COORD_W-1:0]    q_r [LANES];
  logic [wsg_pkg::MAG_W-1:0]      mag_r [LANES];
  logic                           neg_r [LANES];
  logic [wsg_pkg::WT_W-1:0]       w_r;
  logic [wsg_pkg::TGT_W-1:0]      t_r;
  logic                           last_r, skip_r, query_r;
  logic [wsg_pkg::SUM_W-1:0]      sum_r;
  logic [wsg_pkg::OUT_W-1:0]      stress_r;
  logic [wsg_pkg::OUT_W-1:0]      grad_r [LANES];
  logic [1:0]                     fault_r;
  logic [wsg_pkg::DIST_W-1:0]     emag_r;
  logic                           eneg_r;
  logic [wsg_pkg::A_W-1:0]        a_r;
  // iterative unit
  wsg_pkg::op_t                   op_r;
  logic [wsg_pkg::CNT_W-1:0]      cnt_r;
  logic [wsg_pkg::MUL_W-1:0]      mcand_r, prod_r;
  logic [wsg_pkg::MPL_W-1:0]      mpl_r;
  logic [wsg_pkg::SUM_W-1:0]      sq_op_r, sq_res_r, sq_one_r;
  logic [wsg_pkg::NUM_W-1:0]      num_r;
  logic [wsg_pkg::REM_W-1:0]      rem_r;
  logic [wsg_pkg::Q_W-1:0]        quo_r;
  // output register
  logic                           ovalid_r;
  logic [wsg_pkg::OUT_DW-1:0]     odata_r;

  logic [3:0]                     dims_lim;
  logic [wsg_pkg::DIST_W-1:0]     dist_v;
  logic [wsg_pkg::REM_W-1:0]      den;
  logic [wsg_pkg::E_W-1:0]        e_val;
  logic [wsg_pkg::SUM_W:0]        sq_try;
  logic [wsg_pkg::REM_W:0]        rem_try;
  logic [56:0]                    sterm_raw;
  logic [wsg_pkg::OUT_W-1:0]      sterm;
  logic                           sterm_sat, ssum_sat;
  logic signed [wsg_pkg::GS_W-1:0] gq, gsum;
  logic                           gneg;
  logic [wsg_pkg::OUT_DW-1:0]     pack;

  assign dims_lim = (dims_r == 3'd0) ? 4'd1 :
                    ({1'b0, dims_r} > 4'(MAX_DIMS)) ? 4'(MAX_DIMS) : {1'b0, dims_r};
  assign dist_v  = sq_res_r[wsg_pkg::DIST_W-1:0];
  assign den     = {dist_v, 16'b0};
  assign e_val   = {1'b0, dist_v} - {6'b0, t_r};
  assign sq_try  = {1'b0, sq_res_r} + {1'b0, sq_one_r};
  assign rem_try = {rem_r, num_r[wsg_pkg::NUM_W-1]};

  assign sterm_raw = prod_r[wsg_pkg::MUL_W-1:32];
  assign sterm_sat = (sterm_raw[56:48] != '0);
  assign sterm     = sterm_sat ? MASK48 : sterm_raw[47:0];
  assign ssum_sat  = (sterm > (MASK48 - stress_r));

  assign gneg = eneg_r ^ neg_r[lane];
  assign gq   = gneg ? -$signed({2'b0, quo_r}) : $signed({2'b0, quo_r});
  assign gsum = gq + wsg_pkg::GS_W'($signed(grad_r[lane]));

  assign sts.busy      = (op_r != wsg_pkg::OP_NONE);
  assign sts.is_query  = query_r;
  assign sts.skip      = skip_r;
  assign sts.last      = last_r;
  assign sts.dist_zero = (dist_v == '0);
  assign sts.lane_zero = (mag_r[lane] == '0) || (a_r == '0);
  assign sts.out_busy  = ovalid_r && !out_ready;

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  always_comb begin
    pack = '0;
    pack[47:0] = stress_r;
    for (int j = 0; j < LANES; j++) pack[48*(j+1) +: 48] = grad_r[j];
    pack[241:240] = fault_r;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dims_r   <= 3'd2;
      thr_r    <= wsg_pkg::TGT_W'(1);
      op_r     <= wsg_pkg::OP_NONE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_idx)
          wsg_pkg::CFG_DIMS:   dims_r <= cfg_wdata[2:0];
          wsg_pkg::CFG_THRESH: thr_r  <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.start != wsg_pkg::OP_NONE) begin
        op_r <= cmd.start;
        priority case (cmd.start)
          wsg_pkg::OP_SQ, wsg_pkg::OP_GMUL: cnt_r <= wsg_pkg::CNT_W'(wsg_pkg::MAG_W);
          wsg_pkg::OP_E2, wsg_pkg::OP_SQRT: cnt_r <= wsg_pkg::CNT_W'(wsg_pkg::DIST_W);
          wsg_pkg::OP_WE2: cnt_r <= wsg_pkg::CNT_W'(wsg_pkg::WT_W);
          default:         cnt_r <= wsg_pkg::CNT_W'(wsg_pkg::NUM_W);
        endcase
      end else if (op_r != wsg_pkg::OP_NONE) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wsg_pkg::CNT_W'(1)) op_r <= wsg_pkg::OP_NONE;
      end
      if (cmd.emit) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

  // accumulators, query point and fault bits clear at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < LANES; j++) begin
        q_r[j]    <= '0;
        grad_r[j] <= '0;
      end
      stress_r <= '0;
      fault_r  <= '0;
    end else if (in_fire && !in_cmd) begin
      for (int j = 0; j < LANES; j++) begin
        q_r[j]    <= in_data[32*j +: 32];
        grad_r[j] <= '0;
      end
      stress_r <= '0;
      fault_r  <= '0;
    end else if (cmd.emit) begin
      for (int j = 0; j < LANES; j++) grad_r[j] <= '0;
      stress_r <= '0;
      fault_r  <= '0;
    end else if (cmd.acc_stress) begin
      stress_r <= ssum_sat ? MASK48 : stress_r + sterm;
      fault_r  <= fault_r | {sterm_sat || ssum_sat, dist_v == '0};
    end else if (cmd.acc_grad) begin
      if (gsum > SMAX) begin
        grad_r[lane] <= SMAX[47:0];
        fault_r[1]   <= 1'b1;
      end else if (gsum < SMIN) begin
        grad_r[lane] <= SMIN[47:0];
        fault_r[1]   <= 1'b1;
      end else begin
        grad_r[lane] <= gsum[47:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    logic signed [wsg_pkg::MAG_W-1:0] d;
    if (in_fire) begin
      query_r <= !in_cmd;
      last_r  <= in_last;
      w_r     <= in_data[144:128];
      t_r     <= in_data[175:145];
      skip_r  <= (in_data[175:145] < thr_r);
      sum_r   <= '0;
      for (int j = 0; j < LANES; j++) begin
        d = $signed({q_r[j][31], q_r[j]}) - $signed({in_data[32*j+31], in_data[32*j +: 32]});
        if (4'(j) < dims_lim) begin
          mag_r[j] <= d[32] ? wsg_pkg::MAG_W'(-d) : wsg_pkg::MAG_W'(d);
          neg_r[j] <= d[32];
        end else begin
          mag_r[j] <= '0;
          neg_r[j] <= 1'b0;
        end
      end
    end
    if (cmd.acc_sq) sum_r <= sum_r + prod_r[wsg_pkg::SUM_W-1:0];
    if (cmd.latch_e) begin
      eneg_r <= e_val[wsg_pkg::E_W-1];
      emag_r <= e_val[wsg_pkg::E_W-1] ? wsg_pkg::DIST_W'(-e_val)
                                      : e_val[wsg_pkg::DIST_W-1:0];
    end
    if (cmd.acc_stress) a_r <= {wsg_pkg::A_W'(w_r * emag_r)} << 1;
    if (cmd.emit) odata_r <= pack;

    unique case (cmd.start)
      wsg_pkg::OP_SQ: begin
        mcand_r <= wsg_pkg::MUL_W'(mag_r[lane]);
        mpl_r   <= wsg_pkg::MPL_W'(mag_r[lane]);
        prod_r  <= '0;
      end
      wsg_pkg::OP_GMUL: begin
        mcand_r <= wsg_pkg::MUL_W'(a_r);
        mpl_r   <= wsg_pkg::MPL_W'(mag_r[lane]);
        prod_r  <= '0;
      end
      wsg_pkg::OP_E2: begin
        mcand_r <= wsg_pkg::MUL_W'(emag_r);
        mpl_r   <= emag_r;
        prod_r  <= '0;
      end
      wsg_pkg::OP_WE2: begin
        mcand_r <= prod_r;
        mpl_r   <= wsg_pkg::MPL_W'(w_r);
        prod_r  <= '0;
      end
      wsg_pkg::OP_SQRT: begin
        sq_op_r  <= sum_r;
        sq_res_r <= '0;
        sq_one_r <= wsg_pkg::SUM_W'(1) << 70;
      end
      wsg_pkg::OP_GDIV: begin
        num_r <= prod_r[wsg_pkg::NUM_W-1:0];
        rem_r <= '0;
        quo_r <= '0;
      end
      default: begin
        priority case (op_r)
          wsg_pkg::OP_SQ, wsg_pkg::OP_GMUL, wsg_pkg::OP_E2, wsg_pkg::OP_WE2: begin
            if (mpl_r[0]) prod_r <= prod_r + mcand_r;
            mcand_r <= mcand_r << 1;
            mpl_r   <= mpl_r >> 1;
          end
          wsg_pkg::OP_SQRT: begin
            // digit-by-digit root, one result bit a cycle
            if ({1'b0, sq_op_r} >= sq_try) begin
              sq_op_r  <= sq_op_r - sq_try[wsg_pkg::SUM_W-1:0];
              sq_res_r <= (sq_res_r >> 1) + sq_one_r;
            end else begin
              sq_res_r <= sq_res_r >> 1;
            end
            sq_one_r <= sq_one_r >> 2;
          end
          wsg_pkg::OP_GDIV: begin
            num_r <= num_r << 1;
            if (rem_try >= {1'b0, den}) begin
              rem_r <= wsg_pkg::REM_W'(rem_try - {1'b0, den});
              quo_r <= {quo_r[wsg_pkg::Q_W-2:0], 1'b1};
            end else begin
              rem_r <= rem_try[wsg_pkg::REM_W-1:0];
              quo_r <= {quo_r[wsg_pkg::Q_W-2:0], 1'b0};
            end
          end
          default: ;
        endcase
      end
    endcase
  end

endmodule

// File: src/wsg_checker.sv
// port-level checks of the weighted stress gradient unit, bound to the top
// depends on assert_macros.svh and wsg_pkg
`include "assert_macros.svh"

module wsg_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        in_tuser,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [wsg_pkg::OUT_DW-1:0]  out_tdata
);

  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `ASSERT_NEXT(a_out_stable, clk, rst_n, out_tvalid && !out_tready, $stable(out_tdata))
  `ASSERT_NEXT(a_query_silent, clk, rst_n, in_tvalid && in_tready && !in_tuser, !$rose(out_tvalid))
  `ASSERT_NEXT(a_term_busy, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready)
  `ASSERT_PROP(a_pad_zero, clk, rst_n, out_tvalid |-> (out_tdata[247:242] == 6'd0))

endmodule

bind weighted_stress_gradient_unit wsg_checker u_wsg_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/testbench.sv
// testbench for weighted_stress_gradient_unit: stress and gradient words checked
// against an in-bench fixed-point predictor; depends on wsg_pkg and the unit
`timescale 1ns / 100ps

module testbench;

  localparam logic [127:0] MASK48 = 128'hFFFF_FFFF_FFFF;
  localparam longint GRAD_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint GRAD_MIN = -64'sh0000_8000_0000_0000;
  localparam int SETTLE_CYCLES = 800;
  localparam bit CMD_QUERY = 1'b0;
  localparam bit CMD_TERM  = 1'b1;

  typedef struct {
    bit                 cmd;
    logic signed [31:0] coord [wsg_pkg::NCOORD];
    logic [16:0]        weight;
    logic [30:0]        target;
    bit                 last;
  } word_t;

  typedef struct {
    logic [47:0] stress;
    logic [47:0] grad [wsg_pkg::NCOORD];
    logic [1:0]  flags;
  } totals_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [wsg_pkg::IN_DW-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic in_tlast = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [wsg_pkg::OUT_DW-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = wsg_pkg::CFG_DIMS;
  logic [wsg_pkg::CFG_DW-1:0] cfg_data = '0;

  // predictor state
  logic [2:0]         dims_reg;
  logic [30:0]        thresh_reg;
  logic signed [31:0] query_pt [wsg_pkg::NCOORD];
  logic [47:0]        stress_acc;
  longint             grad_acc [wsg_pkg::NCOORD];
  logic [1:0]         fault_acc;

  totals_t pending_totals [$];
  int err_count = 0;
  int words_sent = 0;
  int hold_left = 0;
  bit tx_calm = 1'b0;

  weighted_stress_gradient_unit DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 80);
    return $urandom_range(0, 3);
  endfunction

  function automatic void clear_totals();
    stress_acc = '0;
    fault_acc = '0;
    for (int j = 0; j < wsg_pkg::NCOORD; j++) grad_acc[j] = 0;
  endfunction

  // returns 1 when the word emits totals
  function automatic bit predict_word(input word_t wd, output totals_t res);
    int nd;
    logic signed [33:0] diff [wsg_pkg::NCOORD];
    logic [33:0] mag [wsg_pkg::NCOORD];
    logic [127:0] ssq, dist_v, cand, emag, sterm, a, q;
    logic signed [63:0] e;
    longint s;
    res.stress = '0;
    res.flags = '0;
    for (int j = 0; j < wsg_pkg::NCOORD; j++) res.grad[j] = '0;
    if (wd.cmd == CMD_QUERY) begin
      for (int j = 0; j < wsg_pkg::NCOORD; j++) query_pt[j] = wd.coord[j];
      clear_totals();
      return 1'b0;
    end
    nd = (dims_reg == 0) ? 1 : (dims_reg > wsg_pkg::NCOORD) ? wsg_pkg::NCOORD : int'(dims_reg);
    if (wd.target >= thresh_reg) begin
      ssq = '0;
      for (int j = 0; j < wsg_pkg::NCOORD; j++) begin
        diff[j] = (j < nd) ? query_pt[j] - wd.coord[j] : 34'sd0;
        mag[j] = (diff[j] < 0) ? -diff[j] : diff[j];
        ssq = ssq + 128'(mag[j]) * 128'(mag[j]);
      end
      dist_v = '0;
      for (int b = 36; b >= 0; b--) begin
        cand = dist_v | (128'(1) << b);
        if (cand * cand <= ssq) dist_v = cand;
      end
      e = $signed(dist_v[63:0]) - $signed({33'd0, wd.target});
      emag = (e < 0) ? 128'(-e) : 128'(e);
      sterm = (emag * emag * 128'(wd.weight)) >> 32;
      if (sterm > MASK48) begin
        sterm = MASK48;
        fault_acc[1] = 1'b1;
      end
      if (sterm > MASK48 - 128'(stress_acc)) begin
        stress_acc = MASK48[47:0];
        fault_acc[1] = 1'b1;
      end else begin
        stress_acc = stress_acc + sterm[47:0];
      end
      if (dist_v == 0) begin
        fault_acc[0] = 1'b1;
      end else begin
        a = 128'(2) * 128'(wd.weight) * emag;
        for (int j = 0; j < nd; j++) begin
          if (mag[j] != 0 && a != 0) begin
            q = (a * 128'(mag[j])) / (dist_v << 16);
            s = ((e < 0) != (diff[j] < 0)) ? grad_acc[j] - longint'(q[63:0])
                                           : grad_acc[j] + longint'(q[63:0]);
            if (s > GRAD_MAX) begin
              s = GRAD_MAX;
              fault_acc[1] = 1'b1;
            end else if (s < GRAD_MIN) begin
              s = GRAD_MIN;
              fault_acc[1] = 1'b1;
            end
            grad_acc[j] = s;
          end
        end
      end
    end
    if (!wd.last) return 1'b0;
    res.stress = stress_acc;
    for (int j = 0; j < wsg_pkg::NCOORD; j++) res.grad[j] = grad_acc[j][47:0];
    res.flags = fault_acc;
    clear_totals();
    return 1'b1;
  endfunction

  // result checker
  function automatic void compare_field(string name, logic [47:0] exp_v, logic [47:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t mismatch %s expected %h actual %h", $time, name, exp_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    totals_t exp_t;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_totals.size() == 0) begin
        $display("%0t unexpected result word, expected none actual %h", $time, out_tdata);
        err_count++;
      end else begin
        exp_t = pending_totals.pop_front();
        compare_field("stress", exp_t.stress, out_tdata[47:0]);
        for (int j = 0; j < wsg_pkg::NCOORD; j++)
          compare_field($sformatf("grad_%0d", j), exp_t.grad[j], out_tdata[48*(j+1) +: 48]);
        compare_field("fault_flags", 48'(exp_t.flags), 48'(out_tdata[241:240]));
      end
    end
  end

  // result receiver with random stalls, calm stretches and forced hold-offs
  initial begin
    int stall_left;
    int calm_left;
    stall_left = 0;
    calm_left = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if (calm_left > 0) begin
        out_tready <= 1'b1;
        calm_left--;
      end else begin
        out_tready <= 1'b1;
        if ($urandom_range(0, 39) == 0) calm_left = $urandom_range(100, 400);
        else if ($urandom_range(0, 5) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic send_word(input word_t wd);
    int gap;
    totals_t res;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= wd.cmd;
    in_tlast <= wd.last;
    in_tdata <= {wd.target, wd.weight, wd.coord[3], wd.coord[2], wd.coord[1], wd.coord[0]};
    do @(posedge clk); while (!in_tready);
    if (predict_word(wd, res)) pending_totals.insert(pending_totals.size(), res);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == wsg_pkg::CFG_DIMS) dims_reg = value[2:0];
    else thresh_reg = value;
    @(posedge clk);
  endtask

  function automatic word_t make_word(bit cmd, logic [31:0] c0, logic [31:0] c1,
                                      logic [31:0] c2, logic [31:0] c3,
                                      logic [16:0] w, logic [30:0] t, bit last);
    word_t wd;
    wd.cmd = cmd;
    wd.coord[0] = c0;
    wd.coord[1] = c1;
    wd.coord[2] = c2;
    wd.coord[3] = c3;
    wd.weight = w;
    wd.target = t;
    wd.last = last;
    return wd;
  endfunction

  // a query (skipped in some broken sets) then terms with random content; some sets are broken on purpose
  task automatic send_random_set(input int nterms);
    word_t wd;
    logic signed [31:0] base [wsg_pkg::NCOORD];
    int kind;
    bit broken;
    broken = ($urandom_range(0, 9) == 0);
    for (int j = 0; j < wsg_pkg::NCOORD; j++) base[j] = $urandom;
    if (!broken || $urandom_range(0, 1)) begin
      wd = make_word(CMD_QUERY, base[0], base[1], base[2], base[3],
                     17'($urandom_range(0, 131071)), 31'($urandom),
                     broken && ($urandom_range(0, 1) == 1));
      send_word(wd);
    end else begin
      for (int j = 0; j < wsg_pkg::NCOORD; j++) base[j] = query_pt[j];
    end
    for (int i = 0; i < nterms; i++) begin
      wd.cmd = CMD_TERM;
      for (int j = 0; j < wsg_pkg::NCOORD; j++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) wd.coord[j] = base[j] + $urandom_range(0, 524288) - 32'd262144;
        else if (kind < 9) wd.coord[j] = $urandom;
        else wd.coord[j] = base[j];
      end
      kind = $urandom_range(0, 9);
      wd.weight = (kind < 8) ? 17'($urandom_range(0, 65536)) :
                  (kind == 8) ? 17'($urandom_range(65536, 131071)) :
                  17'(65536 * $urandom_range(0, 1));
      kind = $urandom_range(0, 9);
      if (kind < 6) wd.target = 31'($urandom_range(0, 1 << 20));
      else if (kind < 8) wd.target = 31'($urandom);
      else wd.target = (thresh_reg > 2) ? 31'(thresh_reg + $urandom_range(0, 4) - 31'd2)
                                        : 31'($urandom_range(0, 4));
      wd.last = (i == nterms - 1) || (broken && $urandom_range(0, 3) == 0);
      send_word(wd);
    end
  endtask

  task automatic test_directed();
    // term before any query uses the zero query point: dist 5.0
    send_word(make_word(CMD_TERM, 32'h0003_0000, 32'h0004_0000, 0, 0, 17'h10000,
                        31'h0002_0000, 1'b1));
    // query at the coordinate extremes, last flag set but nothing emitted
    send_word(make_word(CMD_QUERY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                        32'h8000_0000, 17'h1FFFF, 31'h7FFF_FFFF, 1'b1));
    // largest distance, largest weight: stress term saturates
    send_word(make_word(CMD_TERM, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 17'h1FFFF,
                        31'd0, 1'b0));
    send_word(make_word(CMD_TERM, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 17'h1FFFF,
                        31'd0, 1'b1));
    // reference on the query point: zero distance
    send_word(make_word(CMD_TERM, 32'h7FFF_FFFF, 32'h8000_0000, 5, 6, 17'h10000,
                        31'h0005_0000, 1'b1));
    // skipped last term still emits
    send_word(make_word(CMD_TERM, 32'h1234_5678, 32'h0, 0, 0, 17'h10000, 31'd0, 1'b1));
    send_word(make_word(CMD_QUERY, 0, 0, 0, 0, 17'd0, 31'd0, 1'b0));
    // zero weight, one lane with zero difference, target at the extreme
    send_word(make_word(CMD_TERM, 0, 32'h0005_0000, 0, 0, 17'd0, 31'h0001_0000, 1'b1));
    send_word(make_word(CMD_TERM, 0, 32'hFFFB_0000, 0, 0, 17'h10000, 31'h7FFF_FFFF, 1'b1));
    send_word(make_word(CMD_TERM, 32'hFFFF_0000, 32'h0000_8000, 0, 0, 17'h0FFFF,
                        31'h0000_0001, 1'b1));
    wait_idle();
  endtask

  task automatic test_config_sweep();
    logic [2:0] dims_list [6] = '{3'd1, 3'd4, 3'd0, 3'd7, 3'd3, 3'd5};
    logic [30:0] thr_list [6] = '{31'd0, 31'h7FFF_FFFF, 31'h0000_8000, 31'd1,
                                  31'h0002_0000, 31'd0};
    for (int p = 0; p < 6; p++) begin
      write_reg(wsg_pkg::CFG_DIMS, 31'(dims_list[p]));
      write_reg(wsg_pkg::CFG_THRESH, thr_list[p]);
      for (int s = 0; s < 4; s++) send_random_set($urandom_range(1, 4));
      if (thr_list[p] == 31'h7FFF_FFFF)
        send_word(make_word(CMD_TERM, $urandom, $urandom, $urandom, $urandom,
                            17'h10000, 31'h7FFF_FFFF, 1'b1));
      wait_idle();
    end
  endtask

  task automatic test_output_stall();
    write_reg(wsg_pkg::CFG_DIMS, 31'd1);
    hold_left = 4000;
    // results pile up behind the held receiver until the input stalls
    for (int s = 0; s < 4; s++) send_random_set(2);
    // pause the sender until every result has drained
    in_tvalid <= 1'b0;
    while (pending_totals.size() != 0) @(posedge clk);
    send_random_set(3);
    wait_idle();
  endtask

  task automatic test_random_stream();
    while (words_sent < 1150) begin
      if ($urandom_range(0, 24) == 0) begin
        wait_idle();
        write_reg(wsg_pkg::CFG_DIMS, 31'($urandom_range(0, 7)));
        write_reg(wsg_pkg::CFG_THRESH, ($urandom_range(0, 3) == 0) ? 31'($urandom) :
                                       31'($urandom_range(0, 1 << 17)));
      end
      tx_calm = ($urandom_range(0, 4) == 0);
      send_random_set($urandom_range(1, 6));
    end
    tx_calm = 1'b0;
    wait_idle();
  endtask

  initial begin
    dims_reg = 3'd2;
    thresh_reg = 31'd1;
    for (int j = 0; j < wsg_pkg::NCOORD; j++) query_pt[j] = '0;
    clear_totals();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_output_stall();
    test_random_stream();
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
